### rtl/ipfba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP frame byte accounting package
// Shared types, register indexes, protocol constants and address class checks.
// ----------------------------------------------------------------------------
package ipfba_pkg;

    localparam int unsigned LOCAL_V6_SLOTS = 2;
    localparam int unsigned CFG_INDEX_W    = 3;
    localparam int unsigned CFG_DATA_W     = 64;
    localparam int unsigned ADDED_W        = 17;
    localparam int unsigned SUM_W          = 64;

    localparam logic [15:0] KIND_V4         = 16'h0800;
    localparam logic [15:0] KIND_V6         = 16'h86DD;
    localparam logic [16:0] V6_FIXED_HEADER = 17'd40;

    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_LAN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_IPV4      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_V6_COUNT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_V6_A_HIGH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_V6_A_LOW  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_V6_B_HIGH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_V6_B_LOW  = 3'd6;

    typedef enum logic [1:0] {
        OUT_IGNORED   = 2'd0,
        OUT_FILTERED  = 2'd1,
        OUT_ZERO_LEN  = 2'd2,
        OUT_ACCOUNTED = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } t_v6_addr;

    function automatic logic v4_private(input logic [31:0] a);
        logic r;
        r = 1'b0;
        if (a[31:24] == 8'h7F) r = 1'b1;
        if (a[31:24] == 8'h0A) r = 1'b1;
        if ((a & 32'hFFF00000) == 32'hAC100000) r = 1'b1;
        if (a[31:16] == 16'hC0A8) r = 1'b1;
        if (a[31:16] == 16'hA9FE) r = 1'b1;
        if (a[31:28] == 4'hE) r = 1'b1;
        if (a == 32'hFFFFFFFF) r = 1'b1;
        return r;
    endfunction

    function automatic logic v6_private(input t_v6_addr a);
        logic r;
        r = 1'b0;
        if (a.high == 64'd0 && a.low == 64'd1) r = 1'b1;
        if ((a.high[63:56] & 8'hFE) == 8'hFC) r = 1'b1;
        if (a.high[63:56] == 8'hFE && (a.high[55:48] & 8'hC0) == 8'h80) r = 1'b1;
        if (a.high[63:56] == 8'hFF) r = 1'b1;
        return r;
    endfunction

endpackage

### rtl/ip_frame_byte_accounting_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP frame byte accounting
// Parses Ethernet frames byte by byte and keeps 64-bit sent and received
// byte totals for IPv4 and IPv6 traffic, one result per frame.
// ----------------------------------------------------------------------------
// Throughput: one byte item per cycle, frame after frame with no gap, while
// o_in_stall is low. After the last byte of a frame is accepted, its result
// passes the snapshot, decision and output registers in that order.
// Reset: synchronous active-low reset clears the parser position, kind and
// length, pipeline valid flags, both totals and all configuration registers.
module ip_frame_byte_accounting_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [7:0]                            i_frame_byte,
    input  logic                                  i_frame_end,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [1:0]                            o_outcome,
    output logic [ipfba_pkg::ADDED_W-1:0]         o_sent_added,
    output logic [ipfba_pkg::ADDED_W-1:0]         o_received_added,
    output logic [ipfba_pkg::SUM_W-1:0]           o_sent_sum,
    output logic [ipfba_pkg::SUM_W-1:0]           o_received_sum,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ipfba_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ipfba_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration registers.
    logic                   r_filter_lan;
    logic [31:0]            r_local_ipv4;
    logic [1:0]             r_local_v6_count;
    ipfba_pkg::t_v6_addr    r_local_v6 [ipfba_pkg::LOCAL_V6_SLOTS];

    // Frame parser state.
    logic [5:0]             r_pos;
    logic [15:0]            r_kind;
    logic [15:0]            r_len;
    logic [31:0]            r_v4_src;
    logic [31:0]            r_v4_dst;
    ipfba_pkg::t_v6_addr    r_v6_src;
    ipfba_pkg::t_v6_addr    r_v6_dst;

    logic [15:0]            n_kind;
    logic [15:0]            n_len;
    logic [31:0]            n_v4_src;
    logic [31:0]            n_v4_dst;
    ipfba_pkg::t_v6_addr    n_v6_src;
    ipfba_pkg::t_v6_addr    n_v6_dst;

    // Snapshot of a finished frame.
    logic                   r_snap_valid;
    logic                   r_snap_is_v4;
    logic                   r_snap_is_v6;
    logic [15:0]            r_snap_len;
    logic [31:0]            r_snap_v4_src;
    logic [31:0]            r_snap_v4_dst;
    ipfba_pkg::t_v6_addr    r_snap_v6_src;
    ipfba_pkg::t_v6_addr    r_snap_v6_dst;

    // Decision stage.
    logic                   r_dec_valid;
    ipfba_pkg::t_outcome    r_dec_outcome;
    logic [ipfba_pkg::ADDED_W-1:0] r_dec_add_s;
    logic [ipfba_pkg::ADDED_W-1:0] r_dec_add_r;

    ipfba_pkg::t_outcome    n_dec_outcome;
    logic [ipfba_pkg::ADDED_W-1:0] n_dec_add_s;
    logic [ipfba_pkg::ADDED_W-1:0] n_dec_add_r;

    // Output stage; the sum registers are the running totals.
    logic                   r_out_valid;
    ipfba_pkg::t_outcome    r_out_outcome;
    logic [ipfba_pkg::ADDED_W-1:0] r_out_add_s;
    logic [ipfba_pkg::ADDED_W-1:0] r_out_add_r;
    logic [ipfba_pkg::SUM_W-1:0]   r_sent_sum;
    logic [ipfba_pkg::SUM_W-1:0]   r_received_sum;

    logic w_out_ready;
    logic w_dec_ready;
    logic w_snap_ready;
    logic w_in_acc;
    logic w_is_v4;
    logic w_is_v6;

    assign w_out_ready  = !r_out_valid || !i_out_stall;
    assign w_dec_ready  = !r_dec_valid || w_out_ready;
    assign w_snap_ready = !r_snap_valid || w_dec_ready;
    assign w_in_acc     = i_in_valid && w_snap_ready;
    assign o_in_stall   = !w_snap_ready;
    assign o_cfg_ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_lan     <= 1'b0;
            r_local_ipv4     <= '0;
            r_local_v6_count <= '0;
            for (int i = 0; i < ipfba_pkg::LOCAL_V6_SLOTS; i++) begin
                r_local_v6[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ipfba_pkg::REG_FILTER_LAN:      r_filter_lan      <= i_cfg_data[0];
                ipfba_pkg::REG_LOCAL_IPV4:      r_local_ipv4      <= i_cfg_data[31:0];
                ipfba_pkg::REG_LOCAL_V6_COUNT:  r_local_v6_count  <= i_cfg_data[1:0];
                ipfba_pkg::REG_LOCAL_V6_A_HIGH: r_local_v6[0].high <= i_cfg_data;
                ipfba_pkg::REG_LOCAL_V6_A_LOW:  r_local_v6[0].low  <= i_cfg_data;
                ipfba_pkg::REG_LOCAL_V6_B_HIGH: r_local_v6[1].high <= i_cfg_data;
                ipfba_pkg::REG_LOCAL_V6_B_LOW:  r_local_v6[1].low  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_kind   = r_kind;
        n_len    = r_len;
        n_v4_src = r_v4_src;
        n_v4_dst = r_v4_dst;
        n_v6_src = r_v6_src;
        n_v6_dst = r_v6_dst;
        if (r_pos == 6'd12 || r_pos == 6'd13) begin
            n_kind = {r_kind[7:0], i_frame_byte};
        end
        if (((r_pos == 6'd16 || r_pos == 6'd17) && r_kind == ipfba_pkg::KIND_V4) ||
            ((r_pos == 6'd18 || r_pos == 6'd19) && r_kind == ipfba_pkg::KIND_V6)) begin
            n_len = {r_len[7:0], i_frame_byte};
        end
        if (r_pos >= 6'd26 && r_pos <= 6'd29) begin
            n_v4_src = {r_v4_src[23:0], i_frame_byte};
        end
        if (r_pos >= 6'd30 && r_pos <= 6'd33) begin
            n_v4_dst = {r_v4_dst[23:0], i_frame_byte};
        end
        if (r_pos >= 6'd22 && r_pos <= 6'd29) begin
            n_v6_src.high = {r_v6_src.high[55:0], i_frame_byte};
        end
        if (r_pos >= 6'd30 && r_pos <= 6'd37) begin
            n_v6_src.low = {r_v6_src.low[55:0], i_frame_byte};
        end
        if (r_pos >= 6'd38 && r_pos <= 6'd45) begin
            n_v6_dst.high = {r_v6_dst.high[55:0], i_frame_byte};
        end
        if (r_pos >= 6'd46 && r_pos <= 6'd53) begin
            n_v6_dst.low = {r_v6_dst.low[55:0], i_frame_byte};
        end
    end

    assign w_is_v4 = (n_kind == ipfba_pkg::KIND_V4) && (r_pos >= 6'd33);
    assign w_is_v6 = (n_kind == ipfba_pkg::KIND_V6) && (r_pos >= 6'd53);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_kind <= '0;
            r_len  <= '0;
        end else if (w_in_acc) begin
            if (i_frame_end) begin
                r_pos  <= '0;
                r_kind <= '0;
                r_len  <= '0;
            end else begin
                r_pos  <= (r_pos == 6'd63) ? r_pos : r_pos + 6'd1;
                r_kind <= n_kind;
                r_len  <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_v4_src <= n_v4_src;
            r_v4_dst <= n_v4_dst;
            r_v6_src <= n_v6_src;
            r_v6_dst <= n_v6_dst;
        end
        if (w_in_acc && i_frame_end) begin
            r_snap_is_v4  <= w_is_v4;
            r_snap_is_v6  <= w_is_v6;
            r_snap_len    <= n_len;
            r_snap_v4_src <= n_v4_src;
            r_snap_v4_dst <= n_v4_dst;
            r_snap_v6_src <= n_v6_src;
            r_snap_v6_dst <= n_v6_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (w_in_acc && i_frame_end) begin
            r_snap_valid <= 1'b1;
        end else if (w_dec_ready) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_comb begin
        logic       sp;
        logic       dp;
        logic       sl;
        logic       dl;
        logic [1:0] slots;
        logic [ipfba_pkg::ADDED_W-1:0] len_v4;
        logic [ipfba_pkg::ADDED_W-1:0] len_v6;

        n_dec_outcome = ipfba_pkg::OUT_IGNORED;
        n_dec_add_s   = '0;
        n_dec_add_r   = '0;
        slots  = (r_local_v6_count > 2'(ipfba_pkg::LOCAL_V6_SLOTS)) ?
                 2'(ipfba_pkg::LOCAL_V6_SLOTS) : r_local_v6_count;
        len_v4 = {1'b0, r_snap_len};
        len_v6 = ipfba_pkg::V6_FIXED_HEADER + {1'b0, r_snap_len};
        sl = 1'b0;
        dl = 1'b0;
        for (int i = 0; i < ipfba_pkg::LOCAL_V6_SLOTS; i++) begin
            if (2'(i) < slots) begin
                if (r_local_v6[i] == r_snap_v6_src) sl = 1'b1;
                if (r_local_v6[i] == r_snap_v6_dst) dl = 1'b1;
            end
        end
        if (r_snap_is_v4) begin
            sp = ipfba_pkg::v4_private(r_snap_v4_src);
            dp = ipfba_pkg::v4_private(r_snap_v4_dst);
        end else begin
            sp = ipfba_pkg::v6_private(r_snap_v6_src);
            dp = ipfba_pkg::v6_private(r_snap_v6_dst);
        end

        if (r_snap_is_v4) begin
            if (r_filter_lan && sp && dp) begin
                n_dec_outcome = ipfba_pkg::OUT_FILTERED;
            end else if (r_snap_len == 16'd0) begin
                n_dec_outcome = ipfba_pkg::OUT_ZERO_LEN;
            end else begin
                n_dec_outcome = ipfba_pkg::OUT_ACCOUNTED;
                if (r_local_ipv4 != 32'd0) begin
                    if (r_snap_v4_src == r_local_ipv4) begin
                        n_dec_add_s = len_v4;
                    end else if (r_snap_v4_dst == r_local_ipv4) begin
                        n_dec_add_r = len_v4;
                    end
                end else begin
                    if (!sp) n_dec_add_s = len_v4;
                    if (!dp) n_dec_add_r = len_v4;
                end
            end
        end else if (r_snap_is_v6) begin
            if (r_filter_lan && sp && dp) begin
                n_dec_outcome = ipfba_pkg::OUT_FILTERED;
            end else begin
                n_dec_outcome = ipfba_pkg::OUT_ACCOUNTED;
                if (sl && !dl) begin
                    n_dec_add_s = len_v6;
                end else if (!sl) begin
                    n_dec_add_r = len_v6;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else if (w_dec_ready) begin
            r_dec_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dec_ready && r_snap_valid) begin
            r_dec_outcome <= n_dec_outcome;
            r_dec_add_s   <= n_dec_add_s;
            r_dec_add_r   <= n_dec_add_r;
        end
        if (w_out_ready && r_dec_valid) begin
            r_out_outcome <= r_dec_outcome;
            r_out_add_s   <= r_dec_add_s;
            r_out_add_r   <= r_dec_add_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_sent_sum     <= '0;
            r_received_sum <= '0;
        end else if (w_out_ready) begin
            r_out_valid <= r_dec_valid;
            if (r_dec_valid) begin
                r_sent_sum     <= r_sent_sum +
                                  {{(ipfba_pkg::SUM_W-ipfba_pkg::ADDED_W){1'b0}}, r_dec_add_s};
                r_received_sum <= r_received_sum +
                                  {{(ipfba_pkg::SUM_W-ipfba_pkg::ADDED_W){1'b0}}, r_dec_add_r};
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_outcome        = r_out_outcome;
    assign o_sent_added     = r_out_add_s;
    assign o_received_added = r_out_add_r;
    assign o_sent_sum       = r_sent_sum;
    assign o_received_sum   = r_received_sum;

endmodule
